// ===== src/group_norm_forward_macros.svh =====
// Assertion macros used by the group normalisation datapath.
// Define ASSERT_OFF to compile the assertions out.
`ifndef GROUP_NORM_FORWARD_MACROS_SVH
`define GROUP_NORM_FORWARD_MACROS_SVH
`ifndef ASSERT_OFF
`define GNF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("group_norm_forward: assertion failed");
`define GNF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("group_norm_forward: assertion failed");
`else
`define GNF_ASSERT(lbl, clk, rst_n, prop)
`define GNF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/gnf_pkg.sv =====
// ----------------------------------------------------------------------------
// gnf_pkg
// Types and fixed widths shared by the group normalisation block.
// ----------------------------------------------------------------------------
`default_nettype none
package gnf_pkg;

    // Fixed widths of the arithmetic (set by Q8.8 samples and groups up to 64).
    localparam int X_W    = 16;  // sample, gain, bias, normalised result
    localparam int SUM_W  = 23;  // running sum
    localparam int SQ_W   = 38;  // running sum of squares
    localparam int N_W    = 7;   // group size
    localparam int NQ_W   = 45;  // n times sum of squares
    localparam int S2_W   = 46;  // square of the sum
    localparam int D_W    = 43;  // n*Q - S*S
    localparam int NN_W   = 14;  // n*n
    localparam int RAD_W  = 61;  // n*n*2^48 and its quotient by D
    localparam int ROOT_W = 62;  // square root working width
    localparam int T_W    = 24;  // n*sample - sum
    localparam int GT_W   = 40;  // gain * t
    localparam int PP_W   = 53;  // partial product with 12 bits of inv_std
    localparam int P_W    = 64;  // full product
    localparam int V_W    = 40;  // product scaled down by 2^24
    localparam int M_W    = 39;  // magnitude fed to the divide by n
    localparam int INV_W  = 24;  // inverse standard deviation, Q8.16
    localparam int SQRT_STEPS = 31;
    localparam logic [INV_W-1:0] INV_MAX = {INV_W{1'b1}};

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_PROD,
        ST_DIFF,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_INV,
        ST_RD,
        ST_T,
        ST_G,
        ST_PLO,
        ST_PHI,
        ST_RND,
        ST_QDIV_GO,
        ST_QDIV_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic prod;
        logic diff;
        logic div_go;
        logic sq_go;
        logic inv;
        logic rd;
        logic mul_t;
        logic mul_g;
        logic mul_lo;
        logic mul_hi;
        logic rnd;
        logic qdiv_go;
        logic out_load;
        logic idx_inc;
    } cmd_t;

    typedef struct packed {
        logic full_next;
        logic d_zero;
        logic div_busy;
        logic sq_busy;
        logic qdiv_busy;
        logic out_free;
        logic last;
    } stat_t;

endpackage
`default_nettype wire

// ===== src/group_norm_forward.sv =====
// Loading: one sample transfer per cycle; results are computed after the closing sample.
// Group close: statistics run the divider and then the square root; both are skipped if D is 0.
// Each result then passes through the staged product and the divide by the group size.
// Synchronous active-low reset clears the sums, the fill count and all control state.
// The sample store is not cleared; only entries of the current group are read.
// ----------------------------------------------------------------------------
// group_norm_forward
// Group normalisation forward pass on Q8.8 samples with saturated results.
// ----------------------------------------------------------------------------
`default_nettype none
module group_norm_forward #(
    parameter int MAX_GROUP = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // sample[15:0], gain[31:16], bias[47:32]
    input  wire logic        s_tlast,   // group_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // normalized[15:0], inv_std[39:16]
    output logic             m_tlast    // run_end
);

    gnf_pkg::cmd_t  cmd;
    gnf_pkg::stat_t stat;
    logic [gnf_pkg::X_W-1:0]   normalized;
    logic [gnf_pkg::INV_W-1:0] inv_std;

    gnf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gnf_dp #(
        .MAX_GROUP (MAX_GROUP)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_sample     ($signed(s_tdata[15:0])),
        .s_gain       ($signed(s_tdata[31:16])),
        .s_bias       ($signed(s_tdata[47:32])),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_normalized (normalized),
        .m_inv_std    (inv_std),
        .m_run_end    (m_tlast)
    );

    assign m_tdata = {inv_std, normalized};

endmodule
`default_nettype wire

// ===== src/gnf_div.sv =====
// ----------------------------------------------------------------------------
// gnf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gnf_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic      [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] work_reg, work_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    // One shift, compare and subtract step.
    always_comb begin
        rem_sh  = {rem_reg, work_reg[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = (rem_sh >= {1'b0, den_reg});
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            work_next = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            work_next = {work_reg[NUM_W-2:0], ge};
            rem_next  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign quo  = work_reg;

endmodule
`default_nettype wire

// ===== src/gnf_ctrl.sv =====
// ----------------------------------------------------------------------------
// gnf_ctrl
// Sequencer for loading, statistics and per-sample emission.
// ----------------------------------------------------------------------------
`default_nettype none
module gnf_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_tlast,
    output logic               s_tready,
    input  wire gnf_pkg::stat_t stat,
    output gnf_pkg::cmd_t      cmd
);

    gnf_pkg::state_t state_reg, state_next;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gnf_pkg::ST_LOAD: begin
                if (s_tvalid && (s_tlast || stat.full_next)) begin
                    state_next = gnf_pkg::ST_PROD;
                end
            end
            gnf_pkg::ST_PROD: state_next = gnf_pkg::ST_DIFF;
            gnf_pkg::ST_DIFF: state_next = gnf_pkg::ST_DIV_GO;
            gnf_pkg::ST_DIV_GO: begin
                state_next = stat.d_zero ? gnf_pkg::ST_INV : gnf_pkg::ST_DIV_WAIT;
            end
            gnf_pkg::ST_DIV_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = gnf_pkg::ST_SQ_GO;
                end
            end
            gnf_pkg::ST_SQ_GO: state_next = gnf_pkg::ST_SQ_WAIT;
            gnf_pkg::ST_SQ_WAIT: begin
                if (!stat.sq_busy) begin
                    state_next = gnf_pkg::ST_INV;
                end
            end
            gnf_pkg::ST_INV:     state_next = gnf_pkg::ST_RD;
            gnf_pkg::ST_RD:      state_next = gnf_pkg::ST_T;
            gnf_pkg::ST_T:       state_next = gnf_pkg::ST_G;
            gnf_pkg::ST_G:       state_next = gnf_pkg::ST_PLO;
            gnf_pkg::ST_PLO:     state_next = gnf_pkg::ST_PHI;
            gnf_pkg::ST_PHI:     state_next = gnf_pkg::ST_RND;
            gnf_pkg::ST_RND:     state_next = gnf_pkg::ST_QDIV_GO;
            gnf_pkg::ST_QDIV_GO: state_next = gnf_pkg::ST_QDIV_WAIT;
            gnf_pkg::ST_QDIV_WAIT: begin
                if (!stat.qdiv_busy) begin
                    state_next = gnf_pkg::ST_OUT;
                end
            end
            gnf_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    state_next = stat.last ? gnf_pkg::ST_LOAD : gnf_pkg::ST_RD;
                end
            end
            default: state_next = gnf_pkg::ST_LOAD;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            gnf_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            gnf_pkg::ST_PROD:    cmd.prod    = 1'b1;
            gnf_pkg::ST_DIFF:    cmd.diff    = 1'b1;
            gnf_pkg::ST_DIV_GO:  cmd.div_go  = !stat.d_zero;
            gnf_pkg::ST_SQ_GO:   cmd.sq_go   = 1'b1;
            gnf_pkg::ST_INV:     cmd.inv     = 1'b1;
            gnf_pkg::ST_RD:      cmd.rd      = 1'b1;
            gnf_pkg::ST_T:       cmd.mul_t   = 1'b1;
            gnf_pkg::ST_G:       cmd.mul_g   = 1'b1;
            gnf_pkg::ST_PLO:     cmd.mul_lo  = 1'b1;
            gnf_pkg::ST_PHI:     cmd.mul_hi  = 1'b1;
            gnf_pkg::ST_RND:     cmd.rnd     = 1'b1;
            gnf_pkg::ST_QDIV_GO: cmd.qdiv_go = 1'b1;
            gnf_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = stat.last;
                    cmd.idx_inc  = !stat.last;
                end
            end
            default: cmd = '0;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gnf_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/gnf_dp.sv =====
// ----------------------------------------------------------------------------
// gnf_dp
// Sample store, accumulators, statistics and per-sample arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "group_norm_forward_macros.svh"
module gnf_dp #(
    parameter int MAX_GROUP = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire gnf_pkg::cmd_t               cmd,
    output gnf_pkg::stat_t                   stat,
    input  wire logic signed [gnf_pkg::X_W-1:0] s_sample,
    input  wire logic signed [gnf_pkg::X_W-1:0] s_gain,
    input  wire logic signed [gnf_pkg::X_W-1:0] s_bias,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic        [gnf_pkg::X_W-1:0]   m_normalized,
    output logic        [gnf_pkg::INV_W-1:0] m_inv_std,
    output logic                             m_run_end
);

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);

    // Sample store and its registered read port.
    logic [gnf_pkg::X_W-1:0] mem [MAX_GROUP];
    logic signed [gnf_pkg::X_W-1:0] rd_reg;

    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic signed [gnf_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [gnf_pkg::SQ_W-1:0] sq_reg, sq_next;
    logic signed [gnf_pkg::X_W-1:0] gain_reg, bias_reg;
    logic signed [31:0] xsq;
    logic [gnf_pkg::N_W-1:0] n;
    logic signed [gnf_pkg::N_W:0] n_s;

    assign n   = gnf_pkg::N_W'(fill_reg);
    assign n_s = {1'b0, n};
    assign xsq = 32'(s_sample) * 32'(s_sample);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[fill_reg[AW-1:0]] <= s_sample;
        end
        if (cmd.rd) begin
            rd_reg <= mem[idx_reg];
        end
    end

    // Accumulation while loading, cleared when a group has been emitted.
    always_comb begin
        fill_next = fill_reg;
        sum_next  = sum_reg;
        sq_next   = sq_reg;
        idx_next  = idx_reg;
        if (cmd.load) begin
            fill_next = fill_reg + 1'b1;
            sum_next  = sum_reg + gnf_pkg::SUM_W'(s_sample);
            sq_next   = sq_reg + gnf_pkg::SQ_W'(unsigned'(xsq));
        end else if (cmd.clear) begin
            fill_next = '0;
            sum_next  = '0;
            sq_next   = '0;
        end
        if (cmd.inv) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
            idx_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
            sq_reg   <= sq_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gain_reg <= s_gain;
            bias_reg <= s_bias;
        end
    end

    // Group statistics: D = n*Q - S*S.
    logic [gnf_pkg::NQ_W-1:0] nq_reg;
    logic [gnf_pkg::S2_W-1:0] s2_reg;
    logic signed [gnf_pkg::S2_W-1:0] s2;
    logic [gnf_pkg::D_W-1:0] d_reg;
    logic [gnf_pkg::NN_W-1:0] nn;
    logic [gnf_pkg::RAD_W-1:0] rad_num;

    assign s2      = gnf_pkg::S2_W'(sum_reg) * gnf_pkg::S2_W'(sum_reg);
    assign nn      = gnf_pkg::NN_W'(n) * gnf_pkg::NN_W'(n);
    assign rad_num = {nn[gnf_pkg::NN_W-2:0], 48'd0};

    always_ff @(posedge aclk) begin
        if (cmd.prod) begin
            nq_reg <= gnf_pkg::NQ_W'(n) * gnf_pkg::NQ_W'(sq_reg);
            s2_reg <= unsigned'(s2);
        end
        if (cmd.diff) begin
            d_reg <= gnf_pkg::D_W'(gnf_pkg::S2_W'(nq_reg) - s2_reg);
        end
    end

    // Quotient n*n*2^48 / D.
    logic div_busy;
    logic [gnf_pkg::RAD_W-1:0] div_quo;

    gnf_div #(
        .NUM_W (gnf_pkg::RAD_W),
        .DEN_W (gnf_pkg::D_W)
    ) u_rad_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_go),
        .num     (rad_num),
        .den     (d_reg),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    // Integer square root, two radicand bits per cycle.
    logic [gnf_pkg::ROOT_W-1:0] sqv_reg, sqv_next;
    logic [gnf_pkg::ROOT_W-1:0] sqr_reg, sqr_next;
    logic [gnf_pkg::ROOT_W-1:0] sqb_reg, sqb_next;
    logic [gnf_pkg::ROOT_W-1:0] sq_trial;
    logic [4:0] sqc_reg, sqc_next;
    logic sq_busy_reg, sq_busy_next;

    always_comb begin
        sq_trial     = sqr_reg + sqb_reg;
        sqv_next     = sqv_reg;
        sqr_next     = sqr_reg;
        sqb_next     = sqb_reg;
        sqc_next     = sqc_reg;
        sq_busy_next = sq_busy_reg;
        if (cmd.sq_go) begin
            sqv_next     = gnf_pkg::ROOT_W'(div_quo);
            sqr_next     = '0;
            sqb_next     = gnf_pkg::ROOT_W'(1) << 60;
            sqc_next     = 5'(gnf_pkg::SQRT_STEPS);
            sq_busy_next = 1'b1;
        end else if (sq_busy_reg) begin
            if (sqv_reg >= sq_trial) begin
                sqv_next = sqv_reg - sq_trial;
                sqr_next = (sqr_reg >> 1) + sqb_reg;
            end else begin
                sqr_next = sqr_reg >> 1;
            end
            sqb_next     = sqb_reg >> 2;
            sqc_next     = sqc_reg - 1'b1;
            sq_busy_next = (sqc_reg != 5'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_busy_reg <= 1'b0;
            sqc_reg     <= '0;
        end else begin
            sq_busy_reg <= sq_busy_next;
            sqc_reg     <= sqc_next;
        end
    end

    always_ff @(posedge aclk) begin
        sqv_reg <= sqv_next;
        sqr_reg <= sqr_next;
        sqb_reg <= sqb_next;
    end

    // Saturated inverse standard deviation; zero variance gives the maximum.
    logic [gnf_pkg::INV_W-1:0] inv_reg;

    always_ff @(posedge aclk) begin
        if (cmd.inv) begin
            if (d_reg == '0 || sqr_reg > gnf_pkg::ROOT_W'(gnf_pkg::INV_MAX)) begin
                inv_reg <= gnf_pkg::INV_MAX;
            end else begin
                inv_reg <= sqr_reg[gnf_pkg::INV_W-1:0];
            end
        end
    end

    // Per-sample product gain*(n*x - S)*inv_std, in stages.
    logic signed [gnf_pkg::T_W-1:0]  t_reg;
    logic signed [gnf_pkg::GT_W-1:0] gt_reg;
    logic signed [gnf_pkg::PP_W-1:0] plo_reg;
    logic signed [gnf_pkg::PP_W-1:0] plo, phi;
    logic signed [gnf_pkg::P_W-1:0]  p_reg;
    logic [gnf_pkg::P_W-1:0]         u;
    logic [gnf_pkg::V_W-1:0]         v;
    logic [gnf_pkg::M_W-1:0]         m_reg;
    logic                            neg_reg;

    assign plo = gt_reg * $signed({1'b0, inv_reg[11:0]});
    assign phi = gt_reg * $signed({1'b0, inv_reg[23:12]});
    assign u   = unsigned'(p_reg) + gnf_pkg::P_W'({n, 23'd0});
    assign v   = u[gnf_pkg::P_W-1:24];

    always_ff @(posedge aclk) begin
        if (cmd.mul_t) begin
            t_reg <= gnf_pkg::T_W'(n_s) * gnf_pkg::T_W'(rd_reg)
                     - gnf_pkg::T_W'(sum_reg);
        end
        if (cmd.mul_g) begin
            gt_reg <= gnf_pkg::GT_W'(gain_reg) * gnf_pkg::GT_W'(t_reg);
        end
        if (cmd.mul_lo) begin
            plo_reg <= plo;
        end
        if (cmd.mul_hi) begin
            p_reg <= (gnf_pkg::P_W'(phi) <<< 12) + gnf_pkg::P_W'(plo_reg);
        end
        if (cmd.rnd) begin
            // Floor division of a negative value runs on its complement.
            neg_reg <= v[gnf_pkg::V_W-1];
            m_reg   <= v[gnf_pkg::V_W-1] ? ~v[gnf_pkg::M_W-1:0] : v[gnf_pkg::M_W-1:0];
        end
    end

    // Divide by the group size.
    logic qdiv_busy;
    logic [gnf_pkg::M_W-1:0] qdiv_quo;

    gnf_div #(
        .NUM_W (gnf_pkg::M_W),
        .DEN_W (gnf_pkg::N_W)
    ) u_mean_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.qdiv_go),
        .num     (m_reg),
        .den     (n),
        .busy    (qdiv_busy),
        .quo     (qdiv_quo)
    );

    // Add the bias and saturate into the output register.
    logic signed [gnf_pkg::V_W-1:0] q;
    logic signed [gnf_pkg::V_W:0]   y;
    logic [gnf_pkg::X_W-1:0]        y_sat;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic last;

    assign q = neg_reg ? $signed(~{1'b0, qdiv_quo}) : $signed({1'b0, qdiv_quo});
    assign y = (gnf_pkg::V_W+1)'(q) + (gnf_pkg::V_W+1)'(bias_reg);

    always_comb begin
        if (y > 41'sd32767) begin
            y_sat = 16'h7fff;
        end else if (y < -41'sd32768) begin
            y_sat = 16'h8000;
        end else begin
            y_sat = y[gnf_pkg::X_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign last     = ((CW'(idx_reg) + 1'b1) == fill_reg);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_normalized <= y_sat;
            m_inv_std    <= inv_reg;
            m_run_end    <= last;
        end
    end

    assign m_tvalid = out_valid_reg;

    // Status to the controller.
    always_comb begin
        stat           = '0;
        stat.full_next = ((fill_reg + 1'b1) == CW'(MAX_GROUP));
        stat.d_zero    = (d_reg == '0);
        stat.div_busy  = div_busy;
        stat.sq_busy   = sq_busy_reg;
        stat.qdiv_busy = qdiv_busy;
        stat.out_free  = out_free;
        stat.last      = last;
    end

    `GNF_ASSERT(a_fill_in_range, aclk, aresetn, fill_reg <= CW'(MAX_GROUP))
    `GNF_ASSERT(a_units_exclusive, aclk, aresetn, !(div_busy && (sq_busy_reg || qdiv_busy)))
    `GNF_ASSERT(a_load_when_free, aclk, aresetn, cmd.out_load |-> out_free)

endmodule
`default_nettype wire
